// ===== sv/svf_pkg.sv =====
// Package for the state-variable wah filter with cubic soft clip.
// Holds widths, coefficient limits, register indexes and the sequencer state type.
// No dependencies; every other file depends on it.
`default_nettype none

package svf_pkg;

	// Sample and coefficient formats.
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 16;
	localparam int STATE_FRAC     = 24;
	localparam int STATE_BITS     = 32;
	localparam int C_REG_BITS     = 16;
	localparam int D_REG_BITS     = 18;

	// Coefficient ceilings: 0.5 and 2.0 with 16 fractional bits.
	localparam logic [C_REG_BITS-1:0] C_MAX = C_REG_BITS'(1 << (COEF_FRAC_BITS - 1));
	localparam logic [D_REG_BITS-1:0] D_MAX = D_REG_BITS'(2 << COEF_FRAC_BITS);

	// Saturation limits for the filter states and the output sample.
	localparam logic signed [STATE_BITS-1:0]  STATE_MAX  = {1'b0, {(STATE_BITS-1){1'b1}}};
	localparam logic signed [STATE_BITS-1:0]  STATE_MIN  = {1'b1, {(STATE_BITS-1){1'b0}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	// Internal datapath widths.
	localparam int X_BITS     = SAMPLE_BITS + 1;
	localparam int NOTCH_BITS = 35;
	localparam int HIGH_BITS  = 36;
	localparam int MIX_BITS   = STATE_FRAC + 2;
	localparam int MA_BITS    = HIGH_BITS;
	localparam int MB_BITS    = MIX_BITS;
	localparam int PROD_BITS  = MA_BITS + MB_BITS;
	localparam int RND_BITS   = PROD_BITS - COEF_FRAC_BITS;
	localparam int Y_BITS     = MIX_BITS + 3;

	// Rounding offsets for the two product alignments.
	localparam logic signed [PROD_BITS-1:0] HALF_COEF  = PROD_BITS'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [PROD_BITS-1:0] HALF_STATE = PROD_BITS'(1) <<< (STATE_FRAC - 1);

	// Mix clamp at +-1.0.
	localparam logic signed [MIX_BITS-1:0] MIX_ONE = MIX_BITS'(1) <<< STATE_FRAC;

	// APB register map.
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;
	localparam logic REG_COEF_C = 1'b0;
	localparam logic REG_COEF_D = 1'b1;

	// Sequencer states: one step per shared-multiplier use or consume.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ND,
		ST_LC,
		ST_HC,
		ST_HM,
		ST_BU,
		ST_MC,
		ST_MX,
		ST_SQ,
		ST_CU,
		ST_CM,
		ST_OUT
	} svf_state_t;

endpackage

`default_nettype wire

// ===== sv/svf_if.sv =====
// Stream interfaces for input and output samples, valid/ready handshake.
// Depends on svf_pkg for the sample width.
`default_nettype none

interface svf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface svf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [svf_pkg::SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== sv/svf_wah_filter_soft_clip.sv =====
// Each accepted sample is taken in the idle state and then passes through eleven sequencer
// steps before it can leave on the output. The steps are set by six products that
// share a single 36x26 signed multiplier with a registered output, each followed by a step
// that rounds and accumulates it. The input is not ready while a sample is in work; a finished
// sample waits in the last step until the output register is free; the block returns
// to idle only then, so a stalled output adds the stall to the next sample's start.
// Depends on svf_pkg and the interfaces in svf_if.sv.
`default_nettype none

module svf_wah_filter_soft_clip (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [svf_pkg::PADDR_BITS-1:0]    paddr,
	input  wire logic [svf_pkg::PDATA_BITS-1:0]    pwdata,
	output logic      [svf_pkg::PDATA_BITS-1:0]    prdata,
	output logic                                   pready,
	svf_in_if.sink                                 in_ch,
	svf_out_if.source                              out_ch
);
	import svf_pkg::*;

	// Configuration registers.
	logic [C_REG_BITS-1:0] coef_c_q;
	logic [D_REG_BITS-1:0] coef_d_q;
	logic [C_REG_BITS-1:0] c_eff;
	logic [D_REG_BITS-1:0] d_eff;

	// Sequencer and datapath registers.
	svf_state_t state_q, state_d;
	logic signed [X_BITS-1:0]      x_q;
	logic signed [STATE_BITS-1:0]  band_q;
	logic signed [STATE_BITS-1:0]  low_q;
	logic signed [NOTCH_BITS-1:0]  notch_q;
	logic signed [HIGH_BITS-1:0]   high_q;
	logic signed [MIX_BITS-1:0]    mix_q;
	logic signed [MIX_BITS-1:0]    m2_q;
	logic signed [PROD_BITS-1:0]   prod_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic                          out_valid_q;

	// Combinational datapath signals.
	logic                          in_fire;
	logic                          out_load;
	logic signed [MA_BITS-1:0]     mul_a;
	logic signed [MB_BITS-1:0]     mul_b;
	logic signed [PROD_BITS-1:0]   sum16;
	logic signed [PROD_BITS-1:0]   sum24;
	logic signed [RND_BITS-1:0]    rnd;
	logic signed [NOTCH_BITS-1:0]  low_sum;
	logic signed [STATE_BITS-1:0]  low_new;
	logic signed [NOTCH_BITS-1:0]  band_sum;
	logic signed [STATE_BITS-1:0]  band_new;
	logic signed [NOTCH_BITS-1:0]  mix_full;
	logic signed [MIX_BITS-1:0]    mix_clamp;
	logic signed [Y_BITS-1:0]      y_lin;
	logic signed [Y_BITS-1:0]      y_half;
	logic signed [Y_BITS-1:0]      y_q23;
	logic signed [SAMPLE_BITS-1:0] y_sat;

	// APB register file: writes complete in the access phase, no wait states.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_c_q <= '0;
			coef_d_q <= D_MAX;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_COEF_C) begin
				coef_c_q <= pwdata[C_REG_BITS-1:0];
			end else begin
				coef_d_q <= pwdata[D_REG_BITS-1:0];
			end
		end
	end

	// Read back; unaligned addresses read as zero.
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			if (paddr[2] == REG_COEF_C) begin
				prdata = PDATA_BITS'(coef_c_q);
			end else begin
				prdata = PDATA_BITS'(coef_d_q);
			end
		end
	end

	// Coefficient saturation at use.
	assign c_eff = (coef_c_q > C_MAX) ? C_MAX : coef_c_q;
	assign d_eff = (coef_d_q > D_MAX) ? D_MAX : coef_d_q;

	// Handshake.
	assign in_ch.ready       = (state_q == ST_IDLE);
	assign in_fire           = in_ch.valid && in_ch.ready;
	assign out_load          = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_q;

	// Next state and shared multiplier operand selection.
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = ST_ND;
				end
			end
			ST_ND: begin
				mul_a   = MA_BITS'(band_q);
				mul_b   = $signed(MB_BITS'(d_eff));
				state_d = ST_LC;
			end
			ST_LC: begin
				mul_a   = MA_BITS'(band_q);
				mul_b   = $signed(MB_BITS'(c_eff));
				state_d = ST_HC;
			end
			ST_HC: begin
				state_d = ST_HM;
			end
			ST_HM: begin
				mul_a   = high_q;
				mul_b   = $signed(MB_BITS'(c_eff));
				state_d = ST_BU;
			end
			ST_BU: begin
				state_d = ST_MC;
			end
			ST_MC: begin
				mul_a   = MA_BITS'(band_q);
				mul_b   = $signed(MB_BITS'(c_eff));
				state_d = ST_MX;
			end
			ST_MX: begin
				state_d = ST_SQ;
			end
			ST_SQ: begin
				mul_a   = MA_BITS'(mix_q);
				mul_b   = mix_q;
				state_d = ST_CU;
			end
			ST_CU: begin
				state_d = ST_CM;
			end
			ST_CM: begin
				mul_a   = MA_BITS'(m2_q);
				mul_b   = mix_q;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Round the registered product, ties toward plus infinity.
	assign sum16 = prod_q + HALF_COEF;
	assign sum24 = prod_q + HALF_STATE;
	assign rnd   = (state_q == ST_CU || state_q == ST_OUT) ?
		RND_BITS'(sum24 >>> STATE_FRAC) : RND_BITS'(sum16 >>> COEF_FRAC_BITS);

	// State updates with saturation to 32 bits.
	assign low_sum  = NOTCH_BITS'(low_q) + NOTCH_BITS'(rnd);
	assign band_sum = NOTCH_BITS'(band_q) + NOTCH_BITS'(rnd);

	always_comb begin
		if (low_sum > NOTCH_BITS'(STATE_MAX)) begin
			low_new = STATE_MAX;
		end else if (low_sum < NOTCH_BITS'(STATE_MIN)) begin
			low_new = STATE_MIN;
		end else begin
			low_new = STATE_BITS'(low_sum);
		end
		if (band_sum > NOTCH_BITS'(STATE_MAX)) begin
			band_new = STATE_MAX;
		end else if (band_sum < NOTCH_BITS'(STATE_MIN)) begin
			band_new = STATE_MIN;
		end else begin
			band_new = STATE_BITS'(band_sum);
		end
	end

	// Mix, clamped to +-1.0 before the cubic.
	assign mix_full = NOTCH_BITS'(x_q) - NOTCH_BITS'(band_q) + NOTCH_BITS'(rnd);

	always_comb begin
		if (mix_full > NOTCH_BITS'(MIX_ONE)) begin
			mix_clamp = MIX_ONE;
		end else if (mix_full < -NOTCH_BITS'(MIX_ONE)) begin
			mix_clamp = -MIX_ONE;
		end else begin
			mix_clamp = MIX_BITS'(mix_full);
		end
	end

	// Output: (3m - m^3)/2 rounded, then aligned to 23 fractional bits and saturated.
	assign y_lin  = (Y_BITS'(mix_q) <<< 1) + Y_BITS'(mix_q) - Y_BITS'(rnd);
	assign y_half = (y_lin + Y_BITS'(1)) >>> 1;
	assign y_q23  = (y_half + Y_BITS'(1)) >>> 1;

	always_comb begin
		if (y_q23 > Y_BITS'(SAMPLE_MAX)) begin
			y_sat = SAMPLE_MAX;
		end else if (y_q23 < Y_BITS'(SAMPLE_MIN)) begin
			y_sat = SAMPLE_MIN;
		end else begin
			y_sat = SAMPLE_BITS'(y_q23);
		end
	end

	// Shared multiplier; the product holds while the result waits to leave.
	always_ff @(posedge clk) begin
		if (state_q != ST_OUT) begin
			prod_q <= PROD_BITS'(mul_a * mul_b);
		end
	end

	// Filter states.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_q <= '0;
			low_q  <= '0;
		end else begin
			if (state_q == ST_HC) begin
				low_q <= low_new;
			end
			if (state_q == ST_BU) begin
				band_q <= band_new;
			end
		end
	end

	// Payload intermediates.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					x_q <= {in_ch.sample_in, 1'b0};
				end
			end
			ST_LC: begin
				notch_q <= NOTCH_BITS'(x_q) - NOTCH_BITS'(rnd);
			end
			ST_HC: begin
				high_q <= HIGH_BITS'(notch_q) - HIGH_BITS'(low_new);
			end
			ST_MX: begin
				mix_q <= mix_clamp;
			end
			ST_CU: begin
				m2_q <= MIX_BITS'(rnd);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= y_sat;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTH
	// An accepted beat always starts the sequencer.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == ST_ND)
		else $error("sequencer did not start after input beat");

	// The clamped mix stays within +-1.0 when it is squared.
	a_mix_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQ |-> (mix_q <= MIX_ONE) && (mix_q >= -MIX_ONE))
		else $error("mix outside clamp range");

	// A finished sample waits while the output register is still occupied.
	a_out_wait: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT && out_valid_q && !out_ch.ready |=>
		state_q == ST_OUT && out_valid_q)
		else $error("result overwrote a pending output beat");
`endif

endmodule

`default_nettype wire
